[sv/pcvt_pkg.sv]
`timescale 1ns / 1ps

package pcvt_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_HIGH = 3'd0;
    localparam logic [2:0] CFG_RESET_LOW  = 3'd1;
    localparam logic [2:0] CFG_PULSE_HIGH = 3'd2;
    localparam logic [2:0] CFG_PULSE_LOW  = 3'd3;
    localparam logic [2:0] CFG_REPEAT_GAP = 3'd4;

    localparam int CFG_DATA_W = 20;
    localparam int TIME_W     = 16;
    localparam int GAP_W      = 20;

    // Register reset values
    localparam logic [TIME_W-1:0] RESET_HIGH_DEF = 16'd660;
    localparam logic [TIME_W-1:0] RESET_LOW_DEF  = 16'd660;
    localparam logic [TIME_W-1:0] PULSE_HIGH_DEF = 16'd330;
    localparam logic [TIME_W-1:0] PULSE_LOW_DEF  = 16'd330;
    localparam logic [GAP_W-1:0]  REPEAT_GAP_DEF = 20'd300000;

    // Input word
    typedef struct packed {
        logic              kind;
        logic              chip_ready;
        logic [7:0]        pulse_count;
        logic signed [7:0] repeat_count;
    } item_t;

    // Result word
    typedef struct packed {
        logic reset_line;
        logic data_line;
        logic armed;
    } result_t;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [TIME_W-1:0] reset_high_ticks;
        logic [TIME_W-1:0] reset_low_ticks;
        logic [TIME_W-1:0] pulse_high_ticks;
        logic [TIME_W-1:0] pulse_low_ticks;
        logic [GAP_W-1:0]  repeat_gap_ticks;
    } cfg_t;

    // Ticks left after the first tick of a phase; a length of 0 acts as 1
    function automatic logic [GAP_W-1:0] phase_count(input logic [GAP_W-1:0] len);
        phase_count = (len == '0) ? '0 : len - 1'b1;
    endfunction

endpackage

[sv/pcvt_seq.sv]
`timescale 1ns / 1ps

// Pin sequencer: phase, tick counter, pulse and repeat bookkeeping.
module pcvt_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  pcvt_pkg::item_t  item,
    input  pcvt_pkg::cfg_t   cfg,
    output pcvt_pkg::result_t result_next
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_ABORT_HIGH = 3'd1;
    localparam logic [2:0] PH_ABORT_LOW  = 3'd2;
    localparam logic [2:0] PH_RST_HIGH   = 3'd3;
    localparam logic [2:0] PH_RST_LOW    = 3'd4;
    localparam logic [2:0] PH_DATA_HIGH  = 3'd5;
    localparam logic [2:0] PH_DATA_LOW   = 3'd6;
    localparam logic [2:0] PH_GAP        = 3'd7;

    logic [2:0]                  phase_reg, phase_next;
    logic [pcvt_pkg::GAP_W-1:0]  count_reg, count_next;
    logic [7:0]                  done_reg, done_next;
    logic [7:0]                  target_reg, target_next;
    logic [7:0]                  repeats_reg, repeats_next;
    logic                        armed_reg, armed_next;

    logic [7:0] repeats_dec;
    logic [7:0] done_inc;

    assign repeats_dec = repeats_reg - 8'd1;
    assign done_inc    = done_reg + 8'd1;

    // Next state for one word
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        done_next    = done_reg;
        target_next  = target_reg;
        repeats_next = repeats_reg;
        armed_next   = armed_reg;

        if (item.kind)
        begin
            // play request: load counts, abort a live sequence
            target_next  = item.pulse_count;
            repeats_next = item.repeat_count;
            done_next    = '0;
            armed_next   = 1'b1;
            if (armed_reg)
            begin
                phase_next = PH_ABORT_HIGH;
                count_next = pcvt_pkg::phase_count(
                    {{(pcvt_pkg::GAP_W-pcvt_pkg::TIME_W){1'b0}}, cfg.reset_high_ticks});
            end
            else
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            if (armed_reg && repeats_reg != 8'd0 && !repeats_reg[7] && item.chip_ready)
            begin
                phase_next = PH_RST_HIGH;
                count_next = pcvt_pkg::phase_count(
                    {{(pcvt_pkg::GAP_W-pcvt_pkg::TIME_W){1'b0}}, cfg.reset_high_ticks});
            end
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            // phase over: move on
            case (phase_reg)
                PH_ABORT_HIGH, PH_RST_HIGH:
                begin
                    phase_next = (phase_reg == PH_ABORT_HIGH) ? PH_ABORT_LOW : PH_RST_LOW;
                    count_next = pcvt_pkg::phase_count(
                        {{(pcvt_pkg::GAP_W-pcvt_pkg::TIME_W){1'b0}}, cfg.reset_low_ticks});
                end
                PH_DATA_HIGH:
                begin
                    phase_next = PH_DATA_LOW;
                    count_next = pcvt_pkg::phase_count(
                        {{(pcvt_pkg::GAP_W-pcvt_pkg::TIME_W){1'b0}}, cfg.pulse_low_ticks});
                end
                PH_RST_LOW, PH_DATA_LOW:
                begin
                    if (phase_reg == PH_DATA_LOW)
                        done_next = done_inc;
                    else
                        done_next = '0;
                    if ((phase_reg == PH_RST_LOW && target_reg != 8'd0)
                        || (phase_reg == PH_DATA_LOW && done_inc < target_reg))
                    begin
                        phase_next = PH_DATA_HIGH;
                        count_next = pcvt_pkg::phase_count(
                            {{(pcvt_pkg::GAP_W-pcvt_pkg::TIME_W){1'b0}},
                             cfg.pulse_high_ticks});
                    end
                    else
                    begin
                        // repeat finished
                        if (phase_reg == PH_RST_LOW)
                            done_next = done_reg;
                        repeats_next = repeats_dec;
                        count_next   = '0;
                        phase_next   = PH_IDLE;
                        if (repeats_dec != 8'd0 && !repeats_dec[7])
                        begin
                            if (cfg.repeat_gap_ticks != '0)
                            begin
                                phase_next = PH_GAP;
                                count_next = pcvt_pkg::phase_count(cfg.repeat_gap_ticks);
                            end
                        end
                        else
                        begin
                            armed_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    // Pin levels after this word
    always_comb
    begin
        result_next.reset_line = (phase_next == PH_ABORT_HIGH) || (phase_next == PH_RST_HIGH);
        result_next.data_line  = (phase_next == PH_DATA_HIGH);
        result_next.armed      = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            done_reg    <= '0;
            target_reg  <= '0;
            repeats_reg <= '0;
            armed_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            target_reg  <= target_next;
            repeats_reg <= repeats_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

[sv/pulse_count_voice_trigger.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Word
// item      item_valid / item_stall    pcvt_pkg::item_t   (tick or play request)
// result    result_valid / result_stall pcvt_pkg::result_t (pin levels, armed)
// cfg       cfg_valid / cfg_ready      cfg_index[2:0], cfg_data[19:0]
//
// One word per clock while item_stall is low: each accepted item updates the
// sequencer state and loads the result register in the same cycle.
// item_stall rises only while the result register is full and result_stall is high.
// cfg_ready is always high; writes to indexes beyond the list are dropped.
// Reset (rst_n low, asynchronous) loads the default timings and idles the sequencer.
module pulse_count_voice_trigger (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pcvt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output pcvt_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [pcvt_pkg::CFG_DATA_W-1:0] cfg_data
);

    pcvt_pkg::cfg_t    cfg_reg;
    pcvt_pkg::result_t result_reg;
    pcvt_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              item_accept;

    assign cfg_ready    = 1'b1;
    assign item_stall   = result_valid_reg && result_stall;
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_high_ticks <= pcvt_pkg::RESET_HIGH_DEF;
            cfg_reg.reset_low_ticks  <= pcvt_pkg::RESET_LOW_DEF;
            cfg_reg.pulse_high_ticks <= pcvt_pkg::PULSE_HIGH_DEF;
            cfg_reg.pulse_low_ticks  <= pcvt_pkg::PULSE_LOW_DEF;
            cfg_reg.repeat_gap_ticks <= pcvt_pkg::REPEAT_GAP_DEF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcvt_pkg::CFG_RESET_HIGH:
                    cfg_reg.reset_high_ticks <= cfg_data[pcvt_pkg::TIME_W-1:0];
                pcvt_pkg::CFG_RESET_LOW:
                    cfg_reg.reset_low_ticks  <= cfg_data[pcvt_pkg::TIME_W-1:0];
                pcvt_pkg::CFG_PULSE_HIGH:
                    cfg_reg.pulse_high_ticks <= cfg_data[pcvt_pkg::TIME_W-1:0];
                pcvt_pkg::CFG_PULSE_LOW:
                    cfg_reg.pulse_low_ticks  <= cfg_data[pcvt_pkg::TIME_W-1:0];
                pcvt_pkg::CFG_REPEAT_GAP:
                    cfg_reg.repeat_gap_ticks <= cfg_data[pcvt_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    pcvt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (item_accept),
        .item        (item),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    // Result register: loads on accept, drains when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
            result_reg <= result_next;
    end

    // Both pins never driven high together
    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.reset_line && result.data_line))
        else $error("reset and data lines high together");

    // A play request always arms
    a_play_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.kind) |=> (result_valid && result.armed))
        else $error("play request did not arm");

    // Backpressure only while a word waits
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid_reg)
        else $error("input stalled with empty result register");

    // Data pulses only while armed
    a_data_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.data_line) |-> result.armed)
        else $error("data pulse while disarmed");

endmodule
